// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge, masked while reset is high
`define ASSERT_CLKD(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// implication checked at every rising edge, reset included
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/life_pkg.sv -----
// types and constants for the life row step block
// no dependencies; imported by the core, the row calculator, the checker and the testbench
package life_pkg;

   localparam int GRID_WIDTH_W = 7;
   localparam int ROW_BITS_W   = 64;
   localparam int REQ_TDATA_W  = 64;
   localparam int RSP_TDATA_W  = 64;

   localparam logic [GRID_WIDTH_W-1:0] GRID_WIDTH_RESET = 7'd64;

   // neighbor count rules for b3/s23
   localparam int COUNT_W = 4;
   localparam logic [COUNT_W-1:0] BIRTH_COUNT   = 4'd3;
   localparam logic [COUNT_W-1:0] LONELY_COUNT  = 4'd1;
   localparam logic [COUNT_W-1:0] CROWDED_COUNT = 4'd4;

   // result queue
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = 2;
   localparam int CNT_W      = 3;

   typedef struct packed {
      logic                  frame_alive;
      logic                  frame_end;
      logic [ROW_BITS_W-1:0] next_row;
   } rsp_entry_type;

endpackage

// ----- hw/rtl/life_row_calc.sv -----
// one next-generation row from three masked rows, all cells in parallel
// depends on life_pkg
module life_row_calc #(
   parameter int ROW_W = 64
) (
   input  logic [ROW_W-1:0] above,
   input  logic [ROW_W-1:0] mid,
   input  logic [ROW_W-1:0] below,
   input  logic [ROW_W-1:0] mask,
   output logic [ROW_W-1:0] next_row
);
   import life_pkg::*;

   logic [ROW_W-1:0]   a_m, m_m, b_m;
   logic [ROW_W-1:0]   nb [8];
   logic [COUNT_W-1:0] cnt [ROW_W];
   logic [ROW_W-1:0]   raw;

   assign a_m = above & mask;
   assign m_m = mid & mask;
   assign b_m = below & mask;

   // neighbor planes, bit k of each is one neighbor of cell k
   assign nb[0] = a_m << 1;
   assign nb[1] = a_m;
   assign nb[2] = a_m >> 1;
   assign nb[3] = m_m << 1;
   assign nb[4] = m_m >> 1;
   assign nb[5] = b_m << 1;
   assign nb[6] = b_m;
   assign nb[7] = b_m >> 1;

   always_comb begin
      for (int k = 0; k < ROW_W; k++) begin
         cnt[k] = COUNT_W'(nb[0][k]) + COUNT_W'(nb[1][k]) + COUNT_W'(nb[2][k])
                + COUNT_W'(nb[3][k]) + COUNT_W'(nb[4][k]) + COUNT_W'(nb[5][k])
                + COUNT_W'(nb[6][k]) + COUNT_W'(nb[7][k]);
         if (m_m[k]) begin
            raw[k] = (cnt[k] > LONELY_COUNT) && (cnt[k] < CROWDED_COUNT);
         end else begin
            raw[k] = (cnt[k] == BIRTH_COUNT);
         end
      end
   end

   assign next_row = raw & mask;

endmodule

// ----- hw/rtl/life_automaton_row_step_core.sv -----
// top level of the b3/s23 row step block: input stage, row state, result queue
// depends on life_pkg and life_row_calc
//
//   channel  direction  payload
//   csr      in         csr_wr_data = grid_width (7 bits)
//   req      in         tdata = row_bits, tlast = last_row
//   rsp      out        tdata = next_row, tlast = frame_end, tuser = frame_alive
//
// one row word is taken every cycle while the consumer keeps up; each row
// word is registered in the input stage and its result in the queue before rsp shows it
// the bottom row pushes two result words into the queue together (one if alone)
// the four-entry result queue sets the stall point: the input stage moves on
// only with two free entries, so req_tready drops when rsp backs up
// reset clears the row state, the queue and sets grid_width to 64
module life_automaton_row_step_core #(
   parameter int MAX_WIDTH = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   // configuration
   input  logic                               csr_wr_en,
   input  logic [life_pkg::GRID_WIDTH_W-1:0]  csr_wr_data,  // grid_width
   // row words in
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [life_pkg::REQ_TDATA_W-1:0]   req_tdata,    // row_bits[63:0]
   input  logic                               req_tlast,    // last_row
   // result words out
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [life_pkg::RSP_TDATA_W-1:0]   rsp_tdata,    // next_row[63:0]
   output logic                               rsp_tlast,    // frame_end
   output logic                               rsp_tuser     // frame_alive
);
   import life_pkg::*;

   // how many rows of the current frame are held
   typedef enum logic [1:0] {
      HELD_NONE,
      HELD_MID,
      HELD_BOTH
   } held_type;

   // configuration
   logic [GRID_WIDTH_W-1:0] grid_width_ff;
   logic [GRID_WIDTH_W-1:0] grid_width_in;
   logic [GRID_WIDTH_W-1:0] width_eff;
   logic [MAX_WIDTH-1:0]    mask_now;

   // input stage
   logic                 s1_valid_ff, s1_valid_in;
   logic [MAX_WIDTH-1:0] s1_row_ff;
   logic                 s1_last_ff;
   logic [MAX_WIDTH-1:0] s1_mask_ff;
   logic                 req_fire;
   logic                 s1_advance;

   // frame state
   held_type             held_ff, held_in;
   logic [MAX_WIDTH-1:0] upper_ff, upper_in;
   logic [MAX_WIDTH-1:0] middle_ff, middle_in;
   logic                 alive_seen_ff, alive_seen_in;

   // row calculators
   logic [MAX_WIDTH-1:0] calc_a_above, calc_a_mid, calc_a_below, calc_a_row;
   logic [MAX_WIDTH-1:0] calc_b_row;
   logic                 a_alive, b_alive;

   // result queue
   rsp_entry_type        entry_ff [FIFO_DEPTH];
   rsp_entry_type        push0_entry, push1_entry;
   logic                 push0, push1;
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in, wr_ptr_nx;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 rsp_fire;
   logic                 queue_room;

   // ---------------------------------------------------------------
   // width mask, widths above MAX_WIDTH clip to MAX_WIDTH
   // ---------------------------------------------------------------
   assign grid_width_in = csr_wr_en ? csr_wr_data : grid_width_ff;
   assign width_eff = (grid_width_ff > GRID_WIDTH_W'(MAX_WIDTH)) ?
                      GRID_WIDTH_W'(MAX_WIDTH) : grid_width_ff;

   always_comb begin
      for (int k = 0; k < MAX_WIDTH; k++) begin
         mask_now[k] = GRID_WIDTH_W'(k) < width_eff;
      end
   end

   // ---------------------------------------------------------------
   // handshakes
   // ---------------------------------------------------------------
   // two free entries needed since the bottom row pushes two words
   assign queue_room = count_ff <= CNT_W'(FIFO_DEPTH - 2);
   assign s1_advance = s1_valid_ff && queue_room;
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_fire   = req_tvalid && req_tready;
   assign s1_valid_in = req_fire || (s1_valid_ff && !s1_advance);

   assign rsp_tvalid = count_ff != '0;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = RSP_TDATA_W'(entry_ff[rd_ptr_ff].next_row);
   assign rsp_tlast  = entry_ff[rd_ptr_ff].frame_end;
   assign rsp_tuser  = entry_ff[rd_ptr_ff].frame_alive;

   // ---------------------------------------------------------------
   // row calculators
   // a: result for the held middle row (or the lone row of a one-row frame)
   // b: result for the bottom row itself
   // ---------------------------------------------------------------
   assign calc_a_above = (held_ff == HELD_BOTH) ? upper_ff : '0;
   assign calc_a_mid   = (held_ff == HELD_NONE) ? s1_row_ff : middle_ff;
   assign calc_a_below = (held_ff == HELD_NONE) ? '0 : s1_row_ff;

   life_row_calc #(.ROW_W(MAX_WIDTH)) u_calc_a (
      .above    (calc_a_above),
      .mid      (calc_a_mid),
      .below    (calc_a_below),
      .mask     (s1_mask_ff),
      .next_row (calc_a_row)
   );

   life_row_calc #(.ROW_W(MAX_WIDTH)) u_calc_b (
      .above    (middle_ff),
      .mid      (s1_row_ff),
      .below    ('0),
      .mask     (s1_mask_ff),
      .next_row (calc_b_row)
   );

   assign a_alive = calc_a_row != '0;
   assign b_alive = calc_b_row != '0;

   // ---------------------------------------------------------------
   // frame state update and queue pushes
   // ---------------------------------------------------------------
   always_comb begin
      held_in       = held_ff;
      upper_in      = upper_ff;
      middle_in     = middle_ff;
      alive_seen_in = alive_seen_ff;
      push0         = 1'b0;
      push1         = 1'b0;
      push0_entry.next_row    = ROW_BITS_W'(calc_a_row);
      push0_entry.frame_end   = 1'b0;
      push0_entry.frame_alive = 1'b0;
      push1_entry.next_row    = ROW_BITS_W'(calc_b_row);
      push1_entry.frame_end   = 1'b1;
      push1_entry.frame_alive = alive_seen_ff || a_alive || b_alive;

      if (s1_advance) begin
         if (held_ff == HELD_NONE) begin
            if (s1_last_ff) begin
               // one-row frame, rows above and below are dead
               push0 = 1'b1;
               push0_entry.frame_end   = 1'b1;
               push0_entry.frame_alive = a_alive;
               held_in       = HELD_NONE;
               alive_seen_in = 1'b0;
            end else begin
               upper_in  = '0;
               middle_in = s1_row_ff;
               held_in   = HELD_MID;
            end
         end else begin
            push0 = 1'b1;
            if (s1_last_ff) begin
               push1         = 1'b1;
               held_in       = HELD_NONE;
               alive_seen_in = 1'b0;
            end else begin
               upper_in      = middle_ff;
               middle_in     = s1_row_ff;
               held_in       = HELD_BOTH;
               alive_seen_in = alive_seen_ff || a_alive;
            end
         end
      end
   end

   // pointers wrap at the queue depth
   assign wr_ptr_nx = PTR_W'(wr_ptr_ff + 1'b1);
   assign wr_ptr_in = push1 ? PTR_W'(wr_ptr_ff + 2'd2) : (push0 ? wr_ptr_nx : wr_ptr_ff);
   assign rd_ptr_in = rsp_fire ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
   assign count_in  = CNT_W'(count_ff + CNT_W'(push0) + CNT_W'(push1) - CNT_W'(rsp_fire));

   // ---------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff <= GRID_WIDTH_RESET;
         s1_valid_ff   <= 1'b0;
         held_ff       <= HELD_NONE;
         alive_seen_ff <= 1'b0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         grid_width_ff <= grid_width_in;
         s1_valid_ff   <= s1_valid_in;
         held_ff       <= held_in;
         alive_seen_ff <= alive_seen_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         // row masked with the width in force when it arrives
         s1_row_ff  <= req_tdata[MAX_WIDTH-1:0] & mask_now;
         s1_last_ff <= req_tlast;
         s1_mask_ff <= mask_now;
      end
      upper_ff  <= upper_in;
      middle_ff <= middle_in;
      if (push0) begin
         entry_ff[wr_ptr_ff] <= push0_entry;
      end
      if (push1) begin
         entry_ff[wr_ptr_nx] <= push1_entry;
      end
   end

endmodule

// ----- hw/rtl/life_checker.sv -----
// port-level checks for the life row step core, attached by bind
// depends on life_pkg and assert_macros.svh
`include "assert_macros.svh"

module life_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               csr_wr_en,
   input logic [life_pkg::GRID_WIDTH_W-1:0]  csr_wr_data,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [life_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input logic                               req_tlast,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [life_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input logic                               rsp_tlast,
   input logic                               rsp_tuser
);
   import life_pkg::*;

   logic unused_inputs;
   assign unused_inputs = csr_wr_en ^ (^csr_wr_data) ^ req_tvalid ^ (^req_tdata) ^ req_tlast;

   // stalled result word holds
   `ASSERT_CLKD(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser), "rsp word changed while stalled")

   // frame_alive only rides on a frame end word
   `ASSERT_CLKD(a_alive_on_end, clock, reset, rsp_tvalid && rsp_tuser |-> rsp_tlast, "frame_alive set on a word that is not frame end")

   // a live bottom result must report a live frame
   `ASSERT_CLKD(a_end_alive, clock, reset, rsp_tvalid && rsp_tlast && (rsp_tdata != '0) |-> rsp_tuser, "live frame end word without frame_alive")

   // out of reset: queue empty and input open
   `ASSERT_CLK(a_reset_empty, clock, $fell(reset) |-> !rsp_tvalid && req_tready, "block not empty after reset")

endmodule

bind life_automaton_row_step_core life_checker u_life_checker (.*);

// ----- sim/testbench.sv -----
// self-checking bench for life_automaton_row_step_core (b3/s23 row step)
// drives row words, predicts next-generation rows and compares each result word
// depends on life_pkg and the core rtl
`timescale 1ns / 100ps

module testbench;

   import life_pkg::*;

   localparam int ROW_W     = ROW_BITS_W;
   localparam int HOLD_LEN  = 300;   // cycles of the long receiver hold-off
   localparam int DRAIN_GAP = 6;     // settle cycles after the last result word

   typedef struct {
      logic [ROW_W-1:0] bits;
      logic             is_last;
   } row_word_type;

   // clock, reset and block ports, all known from time zero
   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    csr_wr_en   = 1'b0;
   logic [GRID_WIDTH_W-1:0] csr_wr_data = '0;
   logic                    req_tvalid  = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata   = '0;   // row_bits[63:0]
   logic                    req_tlast   = 1'b0; // last_row
   logic                    rsp_tvalid;
   logic                    rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;          // next_row[63:0]
   logic                    rsp_tlast;          // frame_end
   logic                    rsp_tuser;          // frame_alive

   // row words waiting for the driver, filled by the stimulus process
   row_word_type  rows_pending[$];
   // next-generation rows the block still owes, oldest first
   rsp_entry_type next_rows_due[$];

   int rows_queued   = 0;
   int rows_accepted = 0;
   int mismatches    = 0;
   int send_idle_pct = 36;
   int rsp_idle_pct  = 36;
   int hold_requests = 0;   // bumped by stimulus to ask for a long rsp hold-off
   int hold_served   = 0;
   int hold_left     = 0;
   bit req_taken     = 1'b0;

   // predictor copy of the register and the row state
   logic [GRID_WIDTH_W-1:0] grid_width;
   logic [ROW_W-1:0]        row_above;
   logic [ROW_W-1:0]        row_mid;
   logic [1:0]              rows_held;
   logic                    alive_seen;

   life_automaton_row_step_core dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // generous cap, far beyond the slowest correct run
   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // cells at or above the width are dead; widths past 64 clamp to 64
   function automatic logic [ROW_W-1:0] width_mask(input logic [GRID_WIDTH_W-1:0] w);
      if (w >= ROW_W)
         return '1;
      return (64'd1 << w) - 64'd1;
   endfunction

   // one generation of the middle row, dead cells beyond both borders
   function automatic logic [ROW_W-1:0] life_next(input logic [ROW_W-1:0] above,
                                                  input logic [ROW_W-1:0] mid,
                                                  input logic [ROW_W-1:0] below,
                                                  input logic [ROW_W-1:0] mask);
      logic [ROW_W-1:0] a;
      logic [ROW_W-1:0] m;
      logic [ROW_W-1:0] b;
      logic [ROW_W-1:0] nxt;
      int               cnt;
      a   = above & mask;
      m   = mid & mask;
      b   = below & mask;
      nxt = '0;
      for (int k = 0; k < ROW_W; k++) begin
         cnt = int'(a[k]) + int'(b[k]);
         if (k > 0)
            cnt = cnt + int'(a[k-1]) + int'(m[k-1]) + int'(b[k-1]);
         if (k < ROW_W - 1)
            cnt = cnt + int'(a[k+1]) + int'(m[k+1]) + int'(b[k+1]);
         // survive on 2 or 3 neighbors, birth on exactly 3
         nxt[k] = m[k] ? (cnt == 2 || cnt == 3) : (cnt == 3);
      end
      return nxt & mask;
   endfunction

   task automatic start_new_frame();
      row_above  = '0;
      row_mid    = '0;
      rows_held  = '0;
      alive_seen = 1'b0;
   endtask

   task automatic owe_row(input logic [ROW_W-1:0] r, input logic fend, input logic falive);
      rsp_entry_type due;
      due.next_row    = r;
      due.frame_end   = fend;
      due.frame_alive = falive;
      next_rows_due.push_back(due);
   endtask

   // advance the predictor by one accepted row word
   task automatic predict_row(input logic [ROW_W-1:0] bits, input logic is_last);
      logic [ROW_W-1:0] mask;
      logic [ROW_W-1:0] row;
      logic [ROW_W-1:0] r;
      mask = width_mask(grid_width);
      row  = bits & mask;
      if (rows_held == 0) begin
         if (!is_last) begin
            // first row of a frame only fills the window
            row_above = '0;
            row_mid   = row;
            rows_held = 2'd1;
         end else begin
            // single-row frame: dead rows on both sides
            r = life_next('0, row, '0, mask);
            owe_row(r, 1'b1, r != 0);
            start_new_frame();
         end
      end else begin
         r = life_next(rows_held >= 2 ? row_above : '0, row_mid, row, mask);
         if (r != 0)
            alive_seen = 1'b1;
         owe_row(r, 1'b0, 1'b0);
         if (!is_last) begin
            row_above = row_mid;
            row_mid   = row;
            rows_held = 2'd2;
         end else begin
            // bottom row also flushes its own result, dead row below
            r = life_next(row_mid, row, '0, mask);
            if (r != 0)
               alive_seen = 1'b1;
            owe_row(r, 1'b1, alive_seen);
            start_new_frame();
         end
      end
   endtask

   // monitor: check result words, then fold in accepted row words and csr writes
   always @(posedge clock) begin : watch_ports
      rsp_entry_type due;
      if (reset) begin
         grid_width = GRID_WIDTH_RESET;
         start_new_frame();
         req_taken = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (next_rows_due.size() == 0) begin
               $error("unexpected result word: next_row %h frame_end %b frame_alive %b",
                      rsp_tdata, rsp_tlast, rsp_tuser);
               mismatches++;
            end else begin
               due = next_rows_due.pop_front();
               if (rsp_tdata !== due.next_row) begin
                  $error("next_row expected %h actual %h", due.next_row, rsp_tdata);
                  mismatches++;
               end
               if (rsp_tlast !== due.frame_end) begin
                  $error("frame_end expected %b actual %b", due.frame_end, rsp_tlast);
                  mismatches++;
               end
               if (rsp_tuser !== due.frame_alive) begin
                  $error("frame_alive expected %b actual %b", due.frame_alive, rsp_tuser);
                  mismatches++;
               end
            end
         end
         req_taken = req_tvalid && req_tready;
         if (req_taken) begin
            predict_row(req_tdata, req_tlast);
            rows_accepted++;
         end
         if (csr_wr_en)
            grid_width = csr_wr_data;
      end
   end

   // driver: holds a word until taken, then offers the next one or idles
   always @(negedge clock) begin : drive_rows
      row_word_type head;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (rows_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            head = rows_pending.pop_front();
            req_tdata  <= head.bits;
            req_tlast  <= head.is_last;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, plus a long hold-off on request so the queue fills
   always @(negedge clock) begin : drive_ready
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = HOLD_LEN;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task automatic queue_row(input logic [ROW_W-1:0] bits, input logic is_last);
      row_word_type w;
      w.bits    = bits;
      w.is_last = is_last;
      rows_pending.push_back(w);
      rows_queued++;
   endtask

   // block is idle: every word taken, every result back, pipeline settled
   task automatic wait_drained();
      while (rows_accepted != rows_queued || next_rows_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_GAP) @(negedge clock);
   endtask

   task automatic write_width(input logic [GRID_WIDTH_W-1:0] w);
      @(negedge clock);
      csr_wr_data <= w;
      csr_wr_en   <= 1'b1;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // mixed densities so that sparse patterns live on past the first step
   function automatic logic [ROW_W-1:0] random_row();
      logic [ROW_W-1:0] r1;
      logic [ROW_W-1:0] r2;
      logic [ROW_W-1:0] r3;
      r1 = {$urandom, $urandom};
      r2 = {$urandom, $urandom};
      r3 = {$urandom, $urandom};
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2, 3, 4: return r1 & r2;
         5, 6:    return r1;
         7:       return r1 | r2;
         default: return r1 & r2 & r3;
      endcase
   endfunction

   initial begin : stimulus
      int rows_random;
      int phase;
      int frames;
      int height;
      logic [GRID_WIDTH_W-1:0] w;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: single-row frames, full and empty
      queue_row('1, 1'b1);
      queue_row('0, 1'b1);
      // blinker in the middle of the row
      queue_row('0, 1'b0);
      queue_row(64'h0000_0001_C000_0000, 1'b0);
      queue_row('0, 1'b1);
      // fully populated block dies off except at the corners
      queue_row('1, 1'b0);
      queue_row('1, 1'b0);
      queue_row('1, 1'b1);
      // two-row frame with alternating cells
      queue_row(64'h5555_5555_5555_5555, 1'b0);
      queue_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
      // live cells against both side borders
      queue_row(64'h8000_0000_0000_0001, 1'b0);
      queue_row(64'hC000_0000_0000_0003, 1'b0);
      queue_row(64'h8000_0000_0000_0001, 1'b0);
      queue_row('0, 1'b1);
      wait_drained();

      // narrow width: high input bits ignored, high output bits zero
      write_width(7'd5);
      queue_row('1, 1'b0);
      queue_row('1, 1'b1);
      wait_drained();
      // zero width: nothing alive at all
      write_width(7'd0);
      queue_row('1, 1'b0);
      queue_row('1, 1'b1);
      wait_drained();
      // width past the row size clamps to the full row
      write_width(7'd127);
      queue_row('1, 1'b0);
      queue_row(64'h0F0F_F0F0_0F0F_F0F0, 1'b1);
      wait_drained();
      // width changes while a frame is open
      write_width(7'd64);
      queue_row('1, 1'b0);
      wait_drained();
      write_width(7'd10);
      queue_row('1, 1'b0);
      queue_row(64'hFFFF_FFFF_FFFF_FC00, 1'b1);
      wait_drained();

      // random phases, each with its own width and idling mix
      rows_random = 0;
      phase       = 0;
      while (rows_random < 650) begin
         case ($urandom_range(9))
            0:       w = 7'd1;
            1:       w = 7'd64;
            2:       w = GRID_WIDTH_W'($urandom_range(65, 127));
            3:       w = GRID_WIDTH_W'($urandom_range(0, 3));
            default: w = GRID_WIDTH_W'($urandom_range(2, 63));
         endcase
         write_width(w);
         send_idle_pct = (phase == 2) ? 0 : 36;
         rsp_idle_pct  = (phase == 2) ? 0 : 36;
         if (phase == 4 || phase == 9) begin
            // sender keeps offering while the receiver sits out a long stretch
            send_idle_pct = 0;
            hold_requests++;
         end
         frames = $urandom_range(3, 10);
         for (int f = 0; f < frames; f++) begin
            height = ($urandom_range(9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
            for (int r = 0; r < height; r++) begin
               queue_row(random_row(), r == height - 1);
               rows_random++;
            end
         end
         // sometimes leave a frame open across the next width change
         if ($urandom_range(3) == 0) begin
            height = $urandom_range(1, 3);
            for (int r = 0; r < height; r++) begin
               queue_row(random_row(), 1'b0);
               rows_random++;
            end
         end
         wait_drained();
         phase++;
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
